### rtl/tttl_pkg.sv
// ----------------------------------------------------------------------------
// tttl_pkg
// Shared types and constants of the triangle topology to list converter:
// topology codes, register indexes, the register file and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package tttl_pkg;

   // Topology codes as held in the topology register.
   localparam logic [1:0] TOPO_LIST    = 2'd0;
   localparam logic [1:0] TOPO_STRIP   = 2'd1;
   localparam logic [1:0] TOPO_FAN     = 2'd2;
   localparam logic [1:0] TOPO_NONSURF = 2'd3;

   // Register indexes on the control port.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOPOLOGY        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_OFFSET     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLICE_FIRST     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLICE_COUNT     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRIMITIVE_COUNT = 3'd4;

   // Data width of the control port and of every vertex value.
   localparam int unsigned WORD_W = 32;

   // Slice sizes above this limit need 32-bit output indices.
   localparam logic [WORD_W-1:0] WIDE_LIMIT = 32'h0000_FFFF;

   // Position codes: vertices held toward the next triangle.
   localparam logic [1:0] POS_EMPTY = 2'd0;
   localparam logic [1:0] POS_ONE   = 2'd1;
   localparam logic [1:0] POS_TWO   = 2'd2;

   // Outcome codes of one triangle.
   localparam logic OUTCOME_EMIT   = 1'b0;
   localparam logic OUTCOME_REJECT = 1'b1;

   // Register file contents.
   typedef struct packed {
      logic [1:0]        topology;
      logic [WORD_W-1:0] base_offset;
      logic [WORD_W-1:0] slice_first;
      logic [WORD_W-1:0] slice_count;
      logic [WORD_W-1:0] primitive_count;
   } cfg_type;

   // One result beat.
   typedef struct packed {
      logic              outcome;
      logic [WORD_W-1:0] vertex_a;
      logic [WORD_W-1:0] vertex_b;
      logic [WORD_W-1:0] vertex_c;
      logic              wide_indices;
      logic [WORD_W-1:0] emitted_total;
      logic [WORD_W-1:0] rejected_total;
   } result_type;

endpackage : tttl_pkg

`default_nettype wire

### rtl/tttl_channels.sv
// ----------------------------------------------------------------------------
// tttl channels
// Valid/ready channel interfaces for index beats in and triangle beats out.
// ----------------------------------------------------------------------------
`default_nettype none

// Index channel: one raw index per beat.
interface tttl_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] raw_index;
   logic        draw_start;

   modport source (output valid, output raw_index, output draw_start, input ready);
   modport sink   (input valid, input raw_index, input draw_start, output ready);
endinterface : tttl_req_if

// Triangle channel: one emitted or rejected triangle per beat.
interface tttl_rsp_if;
   logic        valid;
   logic        ready;
   logic        outcome;
   logic [31:0] vertex_a;
   logic [31:0] vertex_b;
   logic [31:0] vertex_c;
   logic        wide_indices;
   logic [31:0] emitted_total;
   logic [31:0] rejected_total;

   modport source (output valid, output outcome, output vertex_a, output vertex_b,
                   output vertex_c, output wide_indices, output emitted_total,
                   output rejected_total, input ready);
   modport sink   (input valid, input outcome, input vertex_a, input vertex_b,
                   input vertex_c, input wide_indices, input emitted_total,
                   input rejected_total, output ready);
endinterface : tttl_rsp_if

`default_nettype wire

### rtl/tttl_assembler.sv
// ----------------------------------------------------------------------------
// tttl_assembler
// Holds the anchor and the two latest vertices of the draw, forms a triangle
// from an index once two vertices are held under the current topology, and
// classifies it as degenerate, rejected or emitted. State advances on every step.
// ----------------------------------------------------------------------------
`default_nettype none

module tttl_assembler (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tttl_pkg::cfg_type    cfg,
   input  wire logic                 step,
   input  wire logic [31:0]          vertex,
   input  wire logic                 draw_start,
   output      logic                 result_valid,
   output      tttl_pkg::result_type result
);

   logic [31:0] anchor_ff,   anchor_in;
   logic [31:0] older_ff,    older_in;
   logic [31:0] newer_ff,    newer_in;
   logic [1:0]  position_ff, position_in;
   logic [31:0] tri_num_ff,  tri_num_in;
   logic [31:0] emitted_ff,  emitted_in;
   logic [31:0] rejected_ff, rejected_in;

   logic [1:0]  pos_eff;
   logic [31:0] tri_eff;
   logic [31:0] em_eff;
   logic [31:0] rj_eff;
   logic        skip;
   logic        form_tri;
   logic [31:0] va, vb, vc;
   logic [32:0] da, db, dc;
   logic        in_a, in_b, in_c;
   logic        degenerate;

   // A draw start clears position and counts before the index is used.
   assign pos_eff = draw_start ? tttl_pkg::POS_EMPTY : position_ff;
   assign tri_eff = draw_start ? 32'd0 : tri_num_ff;
   assign em_eff  = draw_start ? 32'd0 : emitted_ff;
   assign rj_eff  = draw_start ? 32'd0 : rejected_ff;

   assign skip = (cfg.topology == tttl_pkg::TOPO_NONSURF) ||
                 (tri_eff >= cfg.primitive_count);
   assign form_tri = !skip && (pos_eff != tttl_pkg::POS_EMPTY) &&
                     (pos_eff != tttl_pkg::POS_ONE);

   // Vertex order of the triangle for the current topology.
   always_comb begin
      va = anchor_ff;
      vb = older_ff;
      vc = vertex;
      case (cfg.topology)
         tttl_pkg::TOPO_STRIP: begin
            if (tri_eff[0]) begin
               va = newer_ff;
               vb = older_ff;
            end else begin
               va = older_ff;
               vb = newer_ff;
            end
         end
         tttl_pkg::TOPO_FAN: begin
            va = anchor_ff;
            vb = newer_ff;
         end
         default: begin
            va = anchor_ff;
            vb = older_ff;
         end
      endcase
   end

   // Slice check: the borrow marks a vertex below the slice.
   assign da = {1'b0, va} - {1'b0, cfg.slice_first};
   assign db = {1'b0, vb} - {1'b0, cfg.slice_first};
   assign dc = {1'b0, vc} - {1'b0, cfg.slice_first};
   assign in_a = !da[32] && (da[31:0] < cfg.slice_count);
   assign in_b = !db[32] && (db[31:0] < cfg.slice_count);
   assign in_c = !dc[32] && (dc[31:0] < cfg.slice_count);
   assign degenerate = (va == vb) || (vb == vc) || (va == vc);

   // Next state and the result of this step.
   always_comb begin
      anchor_in    = anchor_ff;
      older_in     = older_ff;
      newer_in     = newer_ff;
      position_in  = pos_eff;
      tri_num_in   = tri_eff;
      emitted_in   = em_eff;
      rejected_in  = rj_eff;
      result_valid = 1'b0;
      result.outcome        = tttl_pkg::OUTCOME_EMIT;
      result.vertex_a       = da[31:0];
      result.vertex_b       = db[31:0];
      result.vertex_c       = dc[31:0];
      result.wide_indices   = cfg.slice_count > tttl_pkg::WIDE_LIMIT;
      result.emitted_total  = em_eff;
      result.rejected_total = rj_eff;
      if (!skip) begin
         case (pos_eff)
            tttl_pkg::POS_EMPTY: begin
               if (cfg.topology == tttl_pkg::TOPO_STRIP) begin
                  older_in = vertex;
               end else begin
                  anchor_in = vertex;
               end
               position_in = tttl_pkg::POS_ONE;
            end
            tttl_pkg::POS_ONE: begin
               if (cfg.topology == tttl_pkg::TOPO_LIST) begin
                  older_in = vertex;
               end else begin
                  newer_in = vertex;
               end
               position_in = tttl_pkg::POS_TWO;
            end
            default: begin
               case (cfg.topology)
                  tttl_pkg::TOPO_LIST: begin
                     position_in = tttl_pkg::POS_EMPTY;
                  end
                  tttl_pkg::TOPO_STRIP: begin
                     older_in = newer_ff;
                     newer_in = vertex;
                  end
                  default: begin
                     newer_in = vertex;
                  end
               endcase
            end
         endcase
      end
      // Triangle classification.
      if (form_tri) begin
         tri_num_in = tri_eff + 32'd1;
         if (!degenerate) begin
            result_valid = 1'b1;
            if (in_a && in_b && in_c) begin
               emitted_in           = em_eff + 32'd1;
               result.emitted_total = em_eff + 32'd1;
            end else begin
               rejected_in           = rj_eff + 32'd1;
               result.rejected_total = rj_eff + 32'd1;
               result.outcome        = tttl_pkg::OUTCOME_REJECT;
               result.vertex_a       = 32'd0;
               result.vertex_b       = 32'd0;
               result.vertex_c       = 32'd0;
            end
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_ff   <= 32'd0;
         older_ff    <= 32'd0;
         newer_ff    <= 32'd0;
         position_ff <= tttl_pkg::POS_EMPTY;
         tri_num_ff  <= 32'd0;
         emitted_ff  <= 32'd0;
         rejected_ff <= 32'd0;
      end else if (step) begin
         anchor_ff   <= anchor_in;
         older_ff    <= older_in;
         newer_ff    <= newer_in;
         position_ff <= position_in;
         tri_num_ff  <= tri_num_in;
         emitted_ff  <= emitted_in;
         rejected_ff <= rejected_in;
      end
   end

endmodule : tttl_assembler

`default_nettype wire

### rtl/triangle_topology_to_list_core.sv
// Path: a taken index beat is registered in the input stage and its triangle in
// the result register; an index that forms no triangle gives none.
// Throughput: one index beat per cycle. While a result waits for rsp ready one
// more index beat is taken, then the input stalls until the result leaves.
// Reset: synchronous, active high; clears the registers, the held vertices,
// position and counts, and both pipeline stages. No clearing pass follows.
// ----------------------------------------------------------------------------
// triangle_topology_to_list_core
// Converts a stream of triangle list, strip or fan indices into rebased
// triangle-list triples, with slice rejects and per-draw counts.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_topology_to_list_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   tttl_req_if.sink                              req_chan,
   tttl_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_write_enable,
   input  wire logic [tttl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tttl_pkg::WORD_W-1:0]      csr_wdata
);

   tttl_pkg::cfg_type    cfg_ff;
   logic                 s1_valid_ff;
   logic [31:0]          s1_vertex_ff;
   logic                 s1_start_ff;
   logic                 rsp_valid_ff;
   tttl_pkg::result_type rsp_data_ff;
   logic                 out_free;
   logic                 s1_advance;
   logic                 req_take;
   logic                 tri_valid;
   tttl_pkg::result_type tri_result;

   // Register file writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            tttl_pkg::CSR_TOPOLOGY:        cfg_ff.topology        <= csr_wdata[1:0];
            tttl_pkg::CSR_BASE_OFFSET:     cfg_ff.base_offset     <= csr_wdata;
            tttl_pkg::CSR_SLICE_FIRST:     cfg_ff.slice_first     <= csr_wdata;
            tttl_pkg::CSR_SLICE_COUNT:     cfg_ff.slice_count     <= csr_wdata;
            tttl_pkg::CSR_PRIMITIVE_COUNT: cfg_ff.primitive_count <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Handshake: the input stage moves on whenever the result slot is free.
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_take   = req_chan.valid && req_chan.ready;

   // Input stage: the base offset is added on the way in.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_vertex_ff <= req_chan.raw_index + cfg_ff.base_offset;
         s1_start_ff  <= req_chan.draw_start;
      end
   end

   // Triangle assembly and classification.
   tttl_assembler u_assembler (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .step         (s1_advance),
      .vertex       (s1_vertex_ff),
      .draw_start   (s1_start_ff),
      .result_valid (tri_valid),
      .result       (tri_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_advance && tri_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && tri_valid) begin
         rsp_data_ff <= tri_result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.outcome        = rsp_data_ff.outcome;
   assign rsp_chan.vertex_a       = rsp_data_ff.vertex_a;
   assign rsp_chan.vertex_b       = rsp_data_ff.vertex_b;
   assign rsp_chan.vertex_c       = rsp_data_ff.vertex_c;
   assign rsp_chan.wide_indices   = rsp_data_ff.wide_indices;
   assign rsp_chan.emitted_total  = rsp_data_ff.emitted_total;
   assign rsp_chan.rejected_total = rsp_data_ff.rejected_total;

endmodule : triangle_topology_to_list_core

`default_nettype wire

### rtl/tttl_checker.sv
// ----------------------------------------------------------------------------
// tttl_checker
// Port-level checks of the triangle beats of triangle_topology_to_list_core.
// ----------------------------------------------------------------------------
`default_nettype none

module tttl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        outcome,
   input wire logic [31:0] vertex_a,
   input wire logic [31:0] vertex_b,
   input wire logic [31:0] vertex_c
);

   // A stalled beat stays valid.
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("triangle beat dropped while stalled");

   // A stalled beat keeps its vertices.
   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(vertex_a) && $stable(vertex_b) &&
                                  $stable(vertex_c) && $stable(outcome))
      else $error("triangle beat changed while stalled");

   // Rejected triangles carry zero vertices.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && outcome |-> vertex_a == 32'd0 && vertex_b == 32'd0 &&
                               vertex_c == 32'd0)
      else $error("rejected triangle carries vertices");

   // Emitted triangles are never degenerate, rebased or not.
   a_emit_distinct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !outcome |-> vertex_a != vertex_b && vertex_b != vertex_c &&
                                vertex_a != vertex_c)
      else $error("degenerate triangle emitted");

   // Reset leaves no beat pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("triangle beat valid after reset");

endmodule : tttl_checker

bind triangle_topology_to_list_core tttl_checker u_tttl_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .outcome   (rsp_chan.outcome),
   .vertex_a  (rsp_chan.vertex_a),
   .vertex_b  (rsp_chan.vertex_b),
   .vertex_c  (rsp_chan.vertex_c)
);

`default_nettype wire

### tb/triangle_topology_to_list_core_tb.sv
// ----------------------------------------------------------------------------
// triangle_topology_to_list_core_tb
// Drives index beats into the converter and checks every triangle beat that
// comes out. A predictor holds its own copy of the registers and of the held
// vertices, forms the expected triangles as each index beat is taken, and
// compares them in order. A short directed part is followed by random draws
// under several register settings and several idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_topology_to_list_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned SETTLE_CYCLES  = 4;
   localparam int unsigned PHASE_BEATS    = 70;

   typedef struct {
      logic [31:0] raw_index;
      logic        draw_start;
   } index_beat_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_write_enable;
   logic [tttl_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tttl_pkg::WORD_W-1:0]      csr_wdata;

   tttl_req_if req_if ();
   tttl_rsp_if rsp_if ();

   triangle_topology_to_list_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Beats waiting to be offered and triangles waiting to come out.
   index_beat_type       index_beats_q[$];
   tttl_pkg::result_type triangles_due_q[$];

   // Register copy kept by the predictor.
   logic [1:0]  topo_reg;
   logic [31:0] base_reg;
   logic [31:0] first_reg;
   logic [31:0] count_reg;
   logic [31:0] prim_reg;

   // Held vertices and per-draw counters of the predictor.
   logic [31:0] anchor_v;
   logic [31:0] older_v;
   logic [31:0] newer_v;
   logic [1:0]  held_pos;
   logic [31:0] tri_index;
   logic [31:0] emit_cnt;
   logic [31:0] reject_cnt;

   int unsigned    sender_idle_pct;
   int unsigned    receiver_stall_pct;
   int unsigned    idle_cycles;
   int unsigned    mismatches;
   int unsigned    hold_left;
   bit             hold_armed;
   bit             hold_done;
   logic           req_taken;
   index_beat_type next_beat;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Counts the triangle and forms its result unless it is degenerate.
   task automatic close_triangle(input logic [31:0] a, input logic [31:0] b,
                                 input logic [31:0] c);
      tttl_pkg::result_type tri_out;
      logic [31:0]          da;
      logic [31:0]          db;
      logic [31:0]          dc;
      da = a - first_reg;
      db = b - first_reg;
      dc = c - first_reg;
      tri_index = tri_index + 1;
      if (a == b || b == c || a == c) return;
      tri_out.wide_indices = (count_reg > tttl_pkg::WIDE_LIMIT);
      if (a < first_reg || da >= count_reg || b < first_reg || db >= count_reg ||
          c < first_reg || dc >= count_reg) begin
         reject_cnt = reject_cnt + 1;
         tri_out.outcome = tttl_pkg::OUTCOME_REJECT;
         tri_out.vertex_a = '0;
         tri_out.vertex_b = '0;
         tri_out.vertex_c = '0;
      end else begin
         emit_cnt = emit_cnt + 1;
         tri_out.outcome = tttl_pkg::OUTCOME_EMIT;
         tri_out.vertex_a = da;
         tri_out.vertex_b = db;
         tri_out.vertex_c = dc;
      end
      tri_out.emitted_total = emit_cnt;
      tri_out.rejected_total = reject_cnt;
      triangles_due_q.push_back(tri_out);
   endtask

   // Advances the predictor by one taken index beat.
   task automatic convert_index(input logic [31:0] raw, input logic start);
      logic [31:0] v;
      v = raw + base_reg;
      if (start) begin
         held_pos = tttl_pkg::POS_EMPTY;
         tri_index = '0;
         emit_cnt = '0;
         reject_cnt = '0;
      end
      if (topo_reg == tttl_pkg::TOPO_NONSURF || tri_index >= prim_reg) return;
      case (held_pos)
         tttl_pkg::POS_EMPTY: begin
            if (topo_reg == tttl_pkg::TOPO_STRIP) older_v = v;
            else anchor_v = v;
            held_pos = tttl_pkg::POS_ONE;
         end
         tttl_pkg::POS_ONE: begin
            if (topo_reg == tttl_pkg::TOPO_LIST) older_v = v;
            else newer_v = v;
            held_pos = tttl_pkg::POS_TWO;
         end
         default: begin
            if (topo_reg == tttl_pkg::TOPO_LIST) begin
               close_triangle(anchor_v, older_v, v);
               held_pos = tttl_pkg::POS_EMPTY;
            end else if (topo_reg == tttl_pkg::TOPO_STRIP) begin
               // Odd triangles of a strip swap the first two vertices.
               if (tri_index[0]) close_triangle(newer_v, older_v, v);
               else close_triangle(older_v, newer_v, v);
               older_v = newer_v;
               newer_v = v;
            end else begin
               close_triangle(anchor_v, newer_v, v);
               newer_v = v;
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
         mismatches++;
      end
   endtask

   // Writes one register and mirrors it into the predictor copy.
   task automatic write_reg(input logic [tttl_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         tttl_pkg::CSR_TOPOLOGY:        topo_reg = value[1:0];
         tttl_pkg::CSR_BASE_OFFSET:     base_reg = value;
         tttl_pkg::CSR_SLICE_FIRST:     first_reg = value;
         tttl_pkg::CSR_SLICE_COUNT:     count_reg = value;
         tttl_pkg::CSR_PRIMITIVE_COUNT: prim_reg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic push_raw(input logic [31:0] raw, input logic start);
      index_beats_q.push_back('{raw_index: raw, draw_start: start});
   endtask

   // Waits until every beat is taken and every triangle has come out, then
   // lets the pipeline settle so that no index is still in flight.
   task automatic wait_idle();
      while (index_beats_q.size() != 0 || req_if.valid || triangles_due_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Queues one draw of random vertices, mostly inside the slice.
   task automatic queue_draw(input int unsigned len, input bit with_start);
      logic [31:0] v;
      logic [31:0] last_v;
      int unsigned pick;
      last_v = first_reg;
      for (int unsigned k = 0; k < len; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) v = last_v;
         else if (pick < 60 && count_reg != 0)
            v = first_reg + ((count_reg < 64) ? $urandom_range(0, count_reg - 1)
                                              : $urandom_range(0, 63));
         else if (pick < 75 && count_reg != 0) v = first_reg + ($urandom % count_reg);
         else if (pick < 82) v = first_reg + count_reg;
         else if (pick < 88) v = first_reg - 1;
         else v = $urandom;
         last_v = v;
         // A stray draw start in mid-draw breaks the sequence now and then.
         push_raw(v - base_reg, (with_start && k == 0) || $urandom_range(0, 99) == 0);
      end
   endtask

   // Sender: offers the next beat once the current one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (index_beats_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            next_beat = index_beats_q.pop_front();
            req_if.valid <= 1'b1;
            req_if.raw_index <= next_beat.raw_index;
            req_if.draw_start <= next_beat.draw_start;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off counted here.
   always @(negedge clock) begin
      if (hold_armed && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Monitor: predicts on every taken index beat and checks every triangle beat.
   always @(posedge clock) begin
      req_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
         convert_index(req_if.raw_index, req_if.draw_start);
      end
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (triangles_due_q.size() == 0) begin
            $error("triangle beat with no expected triangle");
            mismatches++;
         end else begin
            tttl_pkg::result_type want;
            want = triangles_due_q.pop_front();
            check_field("outcome", 32'(want.outcome), 32'(rsp_if.outcome));
            check_field("vertex_a", want.vertex_a, rsp_if.vertex_a);
            check_field("vertex_b", want.vertex_b, rsp_if.vertex_b);
            check_field("vertex_c", want.vertex_c, rsp_if.vertex_c);
            check_field("wide_indices", 32'(want.wide_indices), 32'(rsp_if.wide_indices));
            check_field("emitted_total", want.emitted_total, rsp_if.emitted_total);
            check_field("rejected_total", want.rejected_total, rsp_if.rejected_total);
         end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
   end

   // Watchdog: ends a run in which no beat moves for too long.
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("triangle_topology_to_list_core_tb NOT OK");
      $finish;
   end

   initial begin
      logic [31:0] value;
      int unsigned queued;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.raw_index = '0;
      req_if.draw_start = 1'b0;
      rsp_if.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      idle_cycles = 0;
      mismatches = 0;
      hold_left = 0;
      hold_armed = 1'b0;
      hold_done = 1'b0;
      req_taken = 1'b0;
      topo_reg = tttl_pkg::TOPO_LIST;
      base_reg = '0;
      first_reg = '0;
      count_reg = '0;
      prim_reg = '0;
      anchor_v = '0;
      older_v = '0;
      newer_v = '0;
      held_pos = tttl_pkg::POS_EMPTY;
      tri_index = '0;
      emit_cnt = '0;
      reject_cnt = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Registers at reset value: a zero primitive count ignores every index.
      push_raw(32'h0000_0000, 1'b1);
      push_raw(32'hFFFF_FFFF, 1'b0);
      push_raw(32'h0000_0005, 1'b0);
      wait_idle();

      // List with a wrapping base: one good triangle, one outside the slice,
      // one degenerate, then the primitive count is reached.
      write_reg(tttl_pkg::CSR_TOPOLOGY, 32'(tttl_pkg::TOPO_LIST));
      write_reg(tttl_pkg::CSR_BASE_OFFSET, 32'hFFFF_FFF0);
      write_reg(tttl_pkg::CSR_SLICE_FIRST, 32'h0000_0000);
      write_reg(tttl_pkg::CSR_SLICE_COUNT, 32'h0001_0000);
      write_reg(tttl_pkg::CSR_PRIMITIVE_COUNT, 32'd3);
      push_raw(32'h10, 1'b1);
      push_raw(32'h11, 1'b0);
      push_raw(32'h12, 1'b0);
      push_raw(32'h0F, 1'b0);
      push_raw(32'h10, 1'b0);
      push_raw(32'h11, 1'b0);
      push_raw(32'h10, 1'b0);
      push_raw(32'h10, 1'b0);
      push_raw(32'h11, 1'b0);
      push_raw(32'h13, 1'b0);
      wait_idle();

      // Strip at the top of the address space, alternating winding.
      write_reg(tttl_pkg::CSR_TOPOLOGY, 32'(tttl_pkg::TOPO_STRIP));
      write_reg(tttl_pkg::CSR_BASE_OFFSET, 32'h0000_0000);
      write_reg(tttl_pkg::CSR_SLICE_FIRST, 32'hFFFF_FFF0);
      write_reg(tttl_pkg::CSR_SLICE_COUNT, 32'h0000_0010);
      write_reg(tttl_pkg::CSR_PRIMITIVE_COUNT, 32'hFFFF_FFFF);
      for (int unsigned k = 0; k < 6; k++) push_raw(32'hFFFF_FFF0 + k, k == 0);
      wait_idle();

      // Topology changed in mid-draw: the held vertices carry over to a fan.
      write_reg(tttl_pkg::CSR_TOPOLOGY, 32'(tttl_pkg::TOPO_FAN));
      push_raw(32'hFFFF_FFF8, 1'b0);
      push_raw(32'hFFFF_FFFF, 1'b0);
      wait_idle();

      // Non-surface topology gives nothing.
      write_reg(tttl_pkg::CSR_TOPOLOGY, 32'(tttl_pkg::TOPO_NONSURF));
      push_raw(32'hFFFF_FFF1, 1'b1);
      push_raw(32'hFFFF_FFF2, 1'b0);
      wait_idle();

      // Random phases under changing registers and idling patterns.
      for (int unsigned phase = 0; phase < 13; phase++) begin
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 55; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 55; end
            default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
         endcase

         if (phase == 6) begin
            // Long receiver hold-off on a dense fan so the block backs up.
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
            write_reg(tttl_pkg::CSR_TOPOLOGY, 32'(tttl_pkg::TOPO_FAN));
            write_reg(tttl_pkg::CSR_BASE_OFFSET, 32'h0000_0000);
            write_reg(tttl_pkg::CSR_SLICE_FIRST, 32'h0000_0100);
            write_reg(tttl_pkg::CSR_SLICE_COUNT, 32'h0000_0400);
            write_reg(tttl_pkg::CSR_PRIMITIVE_COUNT, 32'hFFFF_FFFF);
            @(posedge clock);
            hold_armed = 1'b1;
            queue_draw(PHASE_BEATS, 1'b1);
            wait_idle();
            continue;
         end

         value = $urandom;
         value[1:0] = ($urandom_range(0, 9) == 0) ? tttl_pkg::TOPO_NONSURF
                                                  : 2'($urandom_range(0, 2));
         if ($urandom_range(0, 1) == 0) value[31:2] = '0;
         write_reg(tttl_pkg::CSR_TOPOLOGY, value);
         case ($urandom_range(0, 3))
            0: value = 32'h0000_0000;
            1: value = 32'hFFFF_FFFF;
            default: value = $urandom;
         endcase
         write_reg(tttl_pkg::CSR_BASE_OFFSET, value);
         case ($urandom_range(0, 3))
            0: value = 32'h0000_0000;
            1: value = 32'hFFFF_FFFF - $urandom_range(0, 100);
            default: value = $urandom;
         endcase
         write_reg(tttl_pkg::CSR_SLICE_FIRST, value);
         case ($urandom_range(0, 7))
            0: value = 32'h0000_0000;
            1: value = 32'h0000_0001;
            2: value = 32'h0000_FFFF;
            3: value = 32'h0001_0000;
            4: value = 32'hFFFF_FFFF;
            default: value = $urandom_range(3, 300);
         endcase
         write_reg(tttl_pkg::CSR_SLICE_COUNT, value);
         case ($urandom_range(0, 9))
            0: value = 32'h0000_0000;
            1: value = $urandom_range(1, 6);
            2: value = 32'hFFFF_FFFF;
            3: value = $urandom;
            default: value = $urandom_range(20, 500);
         endcase
         write_reg(tttl_pkg::CSR_PRIMITIVE_COUNT, value);

         // Mostly whole draws; some continue the previous draw without a start.
         queued = 0;
         while (queued < PHASE_BEATS) begin
            int unsigned len;
            len = $urandom_range(3, 30);
            queue_draw(len, $urandom_range(0, 9) != 0);
            queued += len;
         end
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0 && triangles_due_q.size() == 0) begin
         $display("triangle_topology_to_list_core_tb OK");
      end else begin
         $display("triangle_topology_to_list_core_tb NOT OK");
      end
      $finish;
   end

endmodule : triangle_topology_to_list_core_tb

`default_nettype wire

### files.f
rtl/tttl_pkg.sv
rtl/tttl_channels.sv
rtl/tttl_assembler.sv
rtl/triangle_topology_to_list_core.sv
rtl/tttl_checker.sv
tb/triangle_topology_to_list_core_tb.sv
